// File: hw/rtl/nearest_neighbor_upscale_address_assert.svh
`ifndef NEAREST_NEIGHBOR_UPSCALE_ADDRESS_ASSERT_SVH
`define NEAREST_NEIGHBOR_UPSCALE_ADDRESS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define NNU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define NNU_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: hw/rtl/nnu_pkg.sv
package nnu_pkg;

	localparam int COORD_W   = 12;
	localparam int DIM_W     = 13;
	localparam int PITCH_W   = 14;
	localparam int ADDR_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// (2n+1) * extent and 2 * extent
	localparam int NUM_W = COORD_W + 1 + DIM_W;
	localparam int DEN_W = DIM_W + 1;
	// quotient stays below the source extent
	localparam int QUO_W = DIM_W;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_BASE   = 3'd0,
		REG_SOURCE_WIDTH  = 3'd1,
		REG_SOURCE_HEIGHT = 3'd2,
		REG_SOURCE_PITCH  = 3'd3,
		REG_DEST_BASE     = 3'd4,
		REG_DEST_WIDTH    = 3'd5,
		REG_DEST_HEIGHT   = 3'd6,
		REG_DEST_PITCH    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  source_base;
		logic [DIM_W-1:0]   src_width;
		logic [DIM_W-1:0]   src_height;
		logic [PITCH_W-1:0] source_pitch;
		logic [ADDR_W-1:0]  dest_base;
		logic [DIM_W-1:0]   dst_width;
		logic [DIM_W-1:0]   dst_height;
		logic [PITCH_W-1:0] dest_pitch;
	} cfg_t;

	typedef struct packed {
		logic               ok;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} tag_t;

	typedef struct packed {
		tag_t             tag;
		logic [NUM_W-1:0] num_x;
		logic [NUM_W-1:0] num_y;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

// File: hw/rtl/nnu_front.sv
module nnu_front #(
	parameter int unsigned MAX_DIM   = 4096,
	parameter int unsigned MAX_PITCH = 8192
) (
	input  nnu_pkg::cfg_t                     cfg,
	input  logic                              req_valid,
	input  logic                              req_stall,
	input  logic [nnu_pkg::COORD_W-1:0]       dest_x,
	input  logic [nnu_pkg::COORD_W-1:0]       dest_y,
	output logic                              push,
	output nnu_pkg::item_t                    item
);

	logic                        cfg_ok;
	logic                        in_range;
	logic [nnu_pkg::DIM_W-1:0]   odd_x;
	logic [nnu_pkg::DIM_W-1:0]   odd_y;

	always_comb begin
		cfg_ok = (cfg.source_base != '0) && (cfg.dest_base != '0)
			&& (cfg.src_width != '0) && (cfg.src_height != '0)
			&& (cfg.dst_width != '0) && (cfg.dst_height != '0)
			&& (32'(cfg.src_width) <= MAX_DIM) && (32'(cfg.src_height) <= MAX_DIM)
			&& (32'(cfg.dst_width) <= MAX_DIM) && (32'(cfg.dst_height) <= MAX_DIM)
			&& (32'(cfg.source_pitch) <= MAX_PITCH) && (32'(cfg.dest_pitch) <= MAX_PITCH)
			&& ({1'b0, cfg.src_width} <= cfg.source_pitch)
			&& ({1'b0, cfg.dst_width} <= cfg.dest_pitch)
			&& (cfg.src_width <= cfg.dst_width)
			&& (cfg.src_height <= cfg.dst_height);
		in_range = ({1'b0, dest_x} < cfg.dst_width) && ({1'b0, dest_y} < cfg.dst_height);
	end

	// sample at the pixel centre: (2n+1) * source extent
	assign odd_x = {dest_x, 1'b1};
	assign odd_y = {dest_y, 1'b1};

	assign item.tag.ok = cfg_ok && in_range;
	assign item.tag.x  = dest_x;
	assign item.tag.y  = dest_y;
	assign item.num_x  = nnu_pkg::NUM_W'(odd_x) * nnu_pkg::NUM_W'(cfg.src_width);
	assign item.num_y  = nnu_pkg::NUM_W'(odd_y) * nnu_pkg::NUM_W'(cfg.src_height);

	assign push = req_valid && !req_stall;

endmodule

// File: hw/rtl/nnu_fifo.sv
`include "nearest_neighbor_upscale_address_assert.svh"

module nnu_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  nnu_pkg::item_t          wr_item,
	input  logic                    pop,
	output nnu_pkg::item_t          rd_item,
	output nnu_pkg::fifo_status_t   status
);

	nnu_pkg::item_t                    mem_q [0:nnu_pkg::FIFO_DEPTH-1];
	logic [nnu_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [nnu_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [nnu_pkg::FIFO_PTR_W:0]      count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

	assign rd_item      = mem_q[rd_ptr_q];
	assign status.full  = (count_q == (nnu_pkg::FIFO_PTR_W+1)'(nnu_pkg::FIFO_DEPTH));
	assign status.empty = (count_q == '0);

	`NNU_ASSERT_IMP(a_no_overflow, push, !status.full)
	`NNU_ASSERT_IMP(a_no_underflow, pop, !status.empty)
	`NNU_ASSERT_NXT(a_drain_last, (pop && !push && count_q == (nnu_pkg::FIFO_PTR_W+1)'(1)), status.empty)

endmodule

// File: hw/rtl/nnu_back.sv
`include "nearest_neighbor_upscale_address_assert.svh"

module nnu_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nnu_pkg::cfg_t                 cfg,
	input  nnu_pkg::item_t                rd_item,
	input  nnu_pkg::fifo_status_t         status,
	output logic                          pop,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          ok,
	output logic [nnu_pkg::COORD_W-1:0]   source_x,
	output logic [nnu_pkg::COORD_W-1:0]   source_y,
	output logic [nnu_pkg::ADDR_W-1:0]    source_address,
	output logic [nnu_pkg::ADDR_W-1:0]    dest_address
);

	localparam int QW = nnu_pkg::QUO_W;

	logic                           adv;
	logic [nnu_pkg::DEN_W-1:0]      den_x;
	logic [nnu_pkg::DEN_W-1:0]      den_y;

	logic [QW:0]                    vld_s;
	nnu_pkg::tag_t                  tag_s   [0:QW];
	logic [nnu_pkg::NUM_W-1:0]      rem_x_s [0:QW];
	logic [nnu_pkg::NUM_W-1:0]      rem_y_s [0:QW];
	logic [QW-1:0]                  quo_x_s [0:QW];
	logic [QW-1:0]                  quo_y_s [0:QW];

	logic                           vld_sc;
	nnu_pkg::tag_t                  tag_sc;
	logic [QW-1:0]                  sx_sc;
	logic [QW-1:0]                  sy_sc;

	logic                           vld_sm;
	nnu_pkg::tag_t                  tag_sm;
	logic [QW-1:0]                  sx_sm;
	logic [QW-1:0]                  sy_sm;
	logic [nnu_pkg::ADDR_W-1:0]     psrc_sm;
	logic [nnu_pkg::ADDR_W-1:0]     pdst_sm;

	logic                           rsp_valid_q;
	logic                           ok_q;
	logic [nnu_pkg::COORD_W-1:0]    source_x_q;
	logic [nnu_pkg::COORD_W-1:0]    source_y_q;
	logic [nnu_pkg::ADDR_W-1:0]     source_address_q;
	logic [nnu_pkg::ADDR_W-1:0]     dest_address_q;
	logic                           rsp_zero;

	// whole pipe moves unless the output beat is held
	assign adv   = !rsp_valid_q || !rsp_stall;
	assign pop   = adv && !status.empty;
	assign den_x = {cfg.dst_width, 1'b0};
	assign den_y = {cfg.dst_height, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			vld_sc      <= 1'b0;
			vld_sm      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s       <= {vld_s[QW-1:0], !status.empty};
			vld_sc      <= vld_s[QW];
			vld_sm      <= vld_sc;
			rsp_valid_q <= vld_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[0]   <= rd_item.tag;
			rem_x_s[0] <= rd_item.num_x;
			rem_y_s[0] <= rd_item.num_y;
			quo_x_s[0] <= '0;
			quo_y_s[0] <= '0;
		end
	end

	// restoring divider, one quotient bit per stage, MSB first
	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [nnu_pkg::NUM_W-1:0] shx;
		logic [nnu_pkg::NUM_W-1:0] shy;
		logic                      take_x;
		logic                      take_y;

		assign shx    = nnu_pkg::NUM_W'(den_x) << B;
		assign shy    = nnu_pkg::NUM_W'(den_y) << B;
		assign take_x = rem_x_s[k] >= shx;
		assign take_y = rem_y_s[k] >= shy;

		always_ff @(posedge clk) begin
			if (adv) begin
				tag_s[k+1]   <= tag_s[k];
				rem_x_s[k+1] <= take_x ? rem_x_s[k] - shx : rem_x_s[k];
				rem_y_s[k+1] <= take_y ? rem_y_s[k] - shy : rem_y_s[k];
				quo_x_s[k+1] <= {quo_x_s[k][QW-2:0], take_x};
				quo_y_s[k+1] <= {quo_y_s[k][QW-2:0], take_y};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// clamp to the last source pixel
			tag_sc <= tag_s[QW];
			sx_sc  <= (quo_x_s[QW] >= cfg.src_width) ? cfg.src_width - 1'b1
				: quo_x_s[QW];
			sy_sc  <= (quo_y_s[QW] >= cfg.src_height) ? cfg.src_height - 1'b1
				: quo_y_s[QW];

			tag_sm  <= tag_sc;
			sx_sm   <= sx_sc;
			sy_sm   <= sy_sc;
			psrc_sm <= nnu_pkg::ADDR_W'(sy_sc) * nnu_pkg::ADDR_W'(cfg.source_pitch);
			pdst_sm <= nnu_pkg::ADDR_W'(tag_sc.y) * nnu_pkg::ADDR_W'(cfg.dest_pitch);

			ok_q <= tag_sm.ok;
			if (tag_sm.ok) begin
				source_x_q       <= sx_sm[nnu_pkg::COORD_W-1:0];
				source_y_q       <= sy_sm[nnu_pkg::COORD_W-1:0];
				source_address_q <= cfg.source_base + psrc_sm + nnu_pkg::ADDR_W'(sx_sm);
				dest_address_q   <= cfg.dest_base + pdst_sm + nnu_pkg::ADDR_W'(tag_sm.x);
			end else begin
				source_x_q       <= '0;
				source_y_q       <= '0;
				source_address_q <= '0;
				dest_address_q   <= '0;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign ok             = ok_q;
	assign source_x       = source_x_q;
	assign source_y       = source_y_q;
	assign source_address = source_address_q;
	assign dest_address   = dest_address_q;

	assign rsp_zero = (source_address_q == '0) && (dest_address_q == '0)
		&& (source_x_q == '0) && (source_y_q == '0);

	`NNU_ASSERT_IMP(a_refused_zero, (rsp_valid_q && !ok_q), rsp_zero)
	`NNU_ASSERT_IMP(a_sx_in_source, (rsp_valid_q && ok_q), ({1'b0, source_x_q} < cfg.src_width))
	`NNU_ASSERT_NXT(a_ok_reaches_out, (adv && vld_sm && tag_sm.ok), (rsp_valid_q && ok_q))

endmodule

// File: hw/rtl/nearest_neighbor_upscale_address.sv
// Pipeline: a beat accepted on the request side passes the queue, the load stage,
// 13 divider stages, clamp, multiply and address add before it shows as a result;
// a stall on the result side holds every stage in place.
// Throughput: one beat per cycle unless the result side stalls; the 13-stage one-bit-per-stage divider sets latency.
// Reset: arst_n clears the queue and all valid flags at once; registers return
// to bases 0, extents 1, pitches 1.
module nearest_neighbor_upscale_address #(
	parameter int unsigned MAX_DIM   = 4096,
	parameter int unsigned MAX_PITCH = 8192
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [nnu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nnu_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [nnu_pkg::COORD_W-1:0]       dest_x,
	input  logic [nnu_pkg::COORD_W-1:0]       dest_y,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic                              ok,
	output logic [nnu_pkg::COORD_W-1:0]       source_x,
	output logic [nnu_pkg::COORD_W-1:0]       source_y,
	output logic [nnu_pkg::ADDR_W-1:0]        source_address,
	output logic [nnu_pkg::ADDR_W-1:0]        dest_address
);

	nnu_pkg::cfg_t            cfg_q;
	nnu_pkg::item_t           wr_item;
	nnu_pkg::item_t           rd_item;
	nnu_pkg::fifo_status_t    status;
	logic                     push;
	logic                     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_base  <= '0;
			cfg_q.src_width    <= nnu_pkg::DIM_W'(1);
			cfg_q.src_height   <= nnu_pkg::DIM_W'(1);
			cfg_q.source_pitch <= nnu_pkg::PITCH_W'(1);
			cfg_q.dest_base    <= '0;
			cfg_q.dst_width    <= nnu_pkg::DIM_W'(1);
			cfg_q.dst_height   <= nnu_pkg::DIM_W'(1);
			cfg_q.dest_pitch   <= nnu_pkg::PITCH_W'(1);
		end else if (cfg_wr_en) begin
			case (nnu_pkg::cfg_reg_t'(cfg_index))
				nnu_pkg::REG_SOURCE_BASE:   cfg_q.source_base  <= cfg_data;
				nnu_pkg::REG_SOURCE_WIDTH:  cfg_q.src_width    <= cfg_data[nnu_pkg::DIM_W-1:0];
				nnu_pkg::REG_SOURCE_HEIGHT: cfg_q.src_height   <= cfg_data[nnu_pkg::DIM_W-1:0];
				nnu_pkg::REG_SOURCE_PITCH:  cfg_q.source_pitch <= cfg_data[nnu_pkg::PITCH_W-1:0];
				nnu_pkg::REG_DEST_BASE:     cfg_q.dest_base    <= cfg_data;
				nnu_pkg::REG_DEST_WIDTH:    cfg_q.dst_width    <= cfg_data[nnu_pkg::DIM_W-1:0];
				nnu_pkg::REG_DEST_HEIGHT:   cfg_q.dst_height   <= cfg_data[nnu_pkg::DIM_W-1:0];
				nnu_pkg::REG_DEST_PITCH:    cfg_q.dest_pitch   <= cfg_data[nnu_pkg::PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	assign req_stall = status.full;

	nnu_front #(
		.MAX_DIM   (MAX_DIM),
		.MAX_PITCH (MAX_PITCH)
	) u_front (
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.dest_x    (dest_x),
		.dest_y    (dest_y),
		.push      (push),
		.item      (wr_item)
	);

	nnu_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.status  (status)
	);

	nnu_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.rd_item        (rd_item),
		.status         (status),
		.pop            (pop),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.ok             (ok),
		.source_x       (source_x),
		.source_y       (source_y),
		.source_address (source_address),
		.dest_address   (dest_address)
	);

endmodule

// File: tb/tb_nearest_neighbor_upscale_address.sv
`timescale 1ns / 100ps

module tb_nearest_neighbor_upscale_address;

	localparam int unsigned MAX_DIM     = 4096;
	localparam int unsigned MAX_PITCH   = 8192;
	localparam int          CLK_PERIOD  = 8;
	localparam int          NUM_CFG     = 8;
	localparam int          LATENCY     = 17;
	localparam int          RANDOM_BEATS = 1200;
	localparam int          CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic                        ok;
		logic [nnu_pkg::COORD_W-1:0] source_x;
		logic [nnu_pkg::COORD_W-1:0] source_y;
		logic [nnu_pkg::ADDR_W-1:0]  source_address;
		logic [nnu_pkg::ADDR_W-1:0]  dest_address;
	} mapping_t;

	typedef struct {
		mapping_t                    want;
		logic [nnu_pkg::COORD_W-1:0] x;
		logic [nnu_pkg::COORD_W-1:0] y;
	} pending_t;

	typedef struct packed {
		logic [3:0]                  preset;
		logic [nnu_pkg::COORD_W-1:0] x;
		logic [nnu_pkg::COORD_W-1:0] y;
		logic                        typed;
		mapping_t                    want;
	} beat_row_t;

	localparam mapping_t REFUSED = '0;

	// register sets for the directed part
	localparam logic [3:0] P_RESET    = 4'd0;
	localparam logic [3:0] P_SMALL    = 4'd1;
	localparam logic [3:0] P_MAX      = 4'd2;
	localparam logic [3:0] P_SINGLE   = 4'd3;
	localparam logic [3:0] P_NO_SW    = 4'd4;
	localparam logic [3:0] P_SHORT_SP = 4'd5;
	localparam logic [3:0] P_SHRINK_W = 4'd6;
	localparam logic [3:0] P_SHRINK_H = 4'd7;
	localparam logic [3:0] P_WIDE_SW  = 4'd8;
	localparam logic [3:0] P_LONG_SP  = 4'd9;
	localparam logic [3:0] P_NO_DB    = 4'd10;
	localparam logic [3:0] P_SHORT_DP = 4'd11;
	localparam int NUM_PRESETS = 12;

	// source base, width, height, pitch, then dest base, width, height, pitch
	localparam logic [31:0] PRESETS [NUM_PRESETS][NUM_CFG] = '{
		'{32'h0,         32'd1,         32'd1,    32'd1,
		  32'h0,         32'd1,         32'd1,    32'd1},
		'{32'h1000,      32'd3,         32'd2,    32'd5,
		  32'h8000_0000, 32'd8,         32'd5,    32'd8},
		'{32'hFFFF_FFFF, 32'd4096,      32'd4096, 32'd8192,
		  32'hFFFF_F000, 32'd4096,      32'd4096, 32'd8192},
		'{32'h1,         32'd1,         32'd1,    32'd1,
		  32'h1,         32'd4096,      32'd4096, 32'd4096},
		'{32'h1000,      32'd0,         32'd2,    32'd5,
		  32'h8000_0000, 32'd8,         32'd5,    32'd8},
		'{32'h1000,      32'd3,         32'd2,    32'd2,
		  32'h8000_0000, 32'd8,         32'd5,    32'd8},
		'{32'h1000,      32'd3,         32'd2,    32'd5,
		  32'h8000_0000, 32'd2,         32'd5,    32'd8},
		'{32'h1000,      32'd3,         32'd2,    32'd5,
		  32'h8000_0000, 32'd8,         32'd1,    32'd8},
		'{32'h1000,      32'hFFFF_1001, 32'd2,    32'd5,
		  32'h8000_0000, 32'd8,         32'd5,    32'd8},
		'{32'h1000,      32'd3,         32'd2,    32'h3FFF,
		  32'h8000_0000, 32'd8,         32'd5,    32'd8},
		'{32'h1000,      32'd3,         32'd2,    32'd5,
		  32'h0,         32'd8,         32'd5,    32'd8},
		'{32'h1000,      32'd3,         32'd2,    32'd5,
		  32'h8000_0000, 32'd8,         32'd5,    32'd7}
	};

	localparam int NUM_ROWS = 23;
	localparam beat_row_t ROWS [NUM_ROWS] = '{
		'{P_RESET,    12'd0,    12'd0,    1'b1, REFUSED},
		'{P_RESET,    12'd4095, 12'd4095, 1'b1, REFUSED},
		'{P_SMALL,    12'd0,    12'd0,    1'b0, REFUSED},
		'{P_SMALL,    12'd7,    12'd4,    1'b0, REFUSED},
		'{P_SMALL,    12'd3,    12'd2,    1'b0, REFUSED},
		'{P_SMALL,    12'd5,    12'd1,    1'b0, REFUSED},
		'{P_SMALL,    12'd8,    12'd0,    1'b1, REFUSED},
		'{P_SMALL,    12'd0,    12'd5,    1'b1, REFUSED},
		'{P_SMALL,    12'd4095, 12'd4095, 1'b1, REFUSED},
		'{P_MAX,      12'd0,    12'd0,    1'b1,
			'{1'b1, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'hFFFF_F000}},
		'{P_MAX,      12'd4095, 12'd4095, 1'b0, REFUSED},
		'{P_MAX,      12'd2048, 12'd2047, 1'b0, REFUSED},
		'{P_SINGLE,   12'd0,    12'd0,    1'b1,
			'{1'b1, 12'd0, 12'd0, 32'h1, 32'h1}},
		'{P_SINGLE,   12'd4095, 12'd4095, 1'b1,
			'{1'b1, 12'd0, 12'd0, 32'h1, 32'h0100_0000}},
		'{P_SINGLE,   12'd2730, 12'd1365, 1'b0, REFUSED},
		'{P_NO_SW,    12'd1,    12'd1,    1'b1, REFUSED},
		'{P_SHORT_SP, 12'd1,    12'd1,    1'b1, REFUSED},
		'{P_SHRINK_W, 12'd1,    12'd1,    1'b1, REFUSED},
		'{P_SHRINK_H, 12'd1,    12'd1,    1'b1, REFUSED},
		'{P_WIDE_SW,  12'd1,    12'd1,    1'b1, REFUSED},
		'{P_LONG_SP,  12'd1,    12'd1,    1'b1, REFUSED},
		'{P_NO_DB,    12'd1,    12'd1,    1'b1, REFUSED},
		'{P_SHORT_DP, 12'd1,    12'd1,    1'b1, REFUSED}
	};

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [nnu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [nnu_pkg::CFG_DAT_W-1:0] cfg_data  = '0;
	logic                          req_valid = 1'b0;
	logic                          req_stall;
	logic [nnu_pkg::COORD_W-1:0]   dest_x    = '0;
	logic [nnu_pkg::COORD_W-1:0]   dest_y    = '0;
	logic                          rsp_valid;
	logic                          rsp_stall = 1'b0;
	logic                          ok;
	logic [nnu_pkg::COORD_W-1:0]   source_x;
	logic [nnu_pkg::COORD_W-1:0]   source_y;
	logic [nnu_pkg::ADDR_W-1:0]    source_address;
	logic [nnu_pkg::ADDR_W-1:0]    dest_address;

	nnu_pkg::cfg_t shadow_cfg;
	logic [31:0]   cfg_words [NUM_CFG];
	pending_t      mapping_q [$];
	int            fail_count  = 0;
	int            cycle_count = 0;
	int unsigned   rsp_hold    = 0;
	bit            req_quiet   = 1'b0;
	bit            rsp_quiet   = 1'b0;

	nearest_neighbor_upscale_address #(
		.MAX_DIM   (MAX_DIM),
		.MAX_PITCH (MAX_PITCH)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.dest_x         (dest_x),
		.dest_y         (dest_y),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.ok             (ok),
		.source_x       (source_x),
		.source_y       (source_y),
		.source_address (source_address),
		.dest_address   (dest_address)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint unsigned centre_index(input longint unsigned n,
			input longint unsigned dext, input longint unsigned sext);
		longint unsigned idx;
		idx = ((2 * n + 1) * sext) / (2 * dext);
		if (idx >= sext)
			idx = sext - 1;
		return idx;
	endfunction

	function automatic bit cfg_accepts(input nnu_pkg::cfg_t c);
		if (c.source_base == 0 || c.dest_base == 0)
			return 1'b0;
		if (c.src_width == 0 || c.src_height == 0 || c.dst_width == 0 ||
				c.dst_height == 0)
			return 1'b0;
		if (c.src_width > MAX_DIM || c.src_height > MAX_DIM ||
				c.dst_width > MAX_DIM || c.dst_height > MAX_DIM)
			return 1'b0;
		if (c.source_pitch > MAX_PITCH || c.dest_pitch > MAX_PITCH)
			return 1'b0;
		if (c.source_pitch < c.src_width || c.dest_pitch < c.dst_width)
			return 1'b0;
		if (c.dst_width < c.src_width || c.dst_height < c.src_height)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic mapping_t map_pixel(input nnu_pkg::cfg_t c,
			input logic [nnu_pkg::COORD_W-1:0] x, input logic [nnu_pkg::COORD_W-1:0] y);
		mapping_t        r;
		longint unsigned sx, sy, saddr, daddr;
		r = '0;
		if (!cfg_accepts(c) || x >= c.dst_width || y >= c.dst_height)
			return r;
		sx = centre_index(x, c.dst_width, c.src_width);
		sy = centre_index(y, c.dst_height, c.src_height);
		saddr = longint'(c.source_base) + sy * longint'(c.source_pitch) + sx;
		daddr = longint'(c.dest_base) + longint'(y) * longint'(c.dest_pitch) + longint'(x);
		r.ok             = 1'b1;
		r.source_x       = sx[nnu_pkg::COORD_W-1:0];
		r.source_y       = sy[nnu_pkg::COORD_W-1:0];
		r.source_address = saddr[nnu_pkg::ADDR_W-1:0];
		r.dest_address   = daddr[nnu_pkg::ADDR_W-1:0];
		return r;
	endfunction

	function automatic int unsigned draw_gap(input bit quiet);
		if (quiet || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	// fill the bits above the register width with noise half the time
	function automatic logic [31:0] pad_word(input int unsigned v, input int w);
		logic [31:0] noise;
		noise = $urandom_range(0, 1) ? ($urandom << w) : 32'h0;
		return v | noise;
	endfunction

	function automatic logic [nnu_pkg::COORD_W-1:0] pick_coord(
			input logic [nnu_pkg::DIM_W-1:0] extent);
		if (extent == 0 || extent > MAX_DIM || $urandom_range(0, 7) == 0)
			return nnu_pkg::COORD_W'($urandom);
		if ($urandom_range(0, 7) == 0)
			return nnu_pkg::COORD_W'(extent - 1);
		return nnu_pkg::COORD_W'($urandom_range(0, extent - 1));
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_beat();
		pending_t p;
		if (mapping_q.size() == 0) begin
			report_error("result beat with nothing pending");
			return;
		end
		p = mapping_q.pop_front();
		if (ok !== p.want.ok)
			report_error($sformatf("ok at (%0d,%0d): got %0b want %0b",
				p.x, p.y, ok, p.want.ok));
		if (source_x !== p.want.source_x)
			report_error($sformatf("source_x at (%0d,%0d): got %0d want %0d",
				p.x, p.y, source_x, p.want.source_x));
		if (source_y !== p.want.source_y)
			report_error($sformatf("source_y at (%0d,%0d): got %0d want %0d",
				p.x, p.y, source_y, p.want.source_y));
		if (source_address !== p.want.source_address)
			report_error($sformatf("source_address at (%0d,%0d): got %h want %h",
				p.x, p.y, source_address, p.want.source_address));
		if (dest_address !== p.want.dest_address)
			report_error($sformatf("dest_address at (%0d,%0d): got %h want %h",
				p.x, p.y, dest_address, p.want.dest_address));
	endtask

	// result side: take a beat, then hold stall for a drawn number of cycles
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			check_beat();
			rsp_hold = draw_gap(rsp_quiet);
		end else if (rsp_hold != 0) begin
			rsp_hold = rsp_hold - 1;
		end
		rsp_stall <= (rsp_hold != 0);
	end

	task automatic send_beat(input logic [nnu_pkg::COORD_W-1:0] x,
			input logic [nnu_pkg::COORD_W-1:0] y, input logic typed, input mapping_t want);
		int unsigned gap;
		pending_t    p;
		gap = draw_gap(req_quiet);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		dest_x    <= x;
		dest_y    <= y;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		p.x    = x;
		p.y    = y;
		p.want = typed ? want : map_pixel(shadow_cfg, x, y);
		mapping_q.push_back(p);
	endtask

	// drain every pending result, then let the pipeline settle
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (mapping_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config();
		for (int i = 0; i < NUM_CFG; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= nnu_pkg::cfg_reg_t'(i);
			cfg_data  <= cfg_words[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		shadow_cfg.source_base  = cfg_words[nnu_pkg::REG_SOURCE_BASE];
		shadow_cfg.src_width    = cfg_words[nnu_pkg::REG_SOURCE_WIDTH][nnu_pkg::DIM_W-1:0];
		shadow_cfg.src_height   = cfg_words[nnu_pkg::REG_SOURCE_HEIGHT][nnu_pkg::DIM_W-1:0];
		shadow_cfg.source_pitch = cfg_words[nnu_pkg::REG_SOURCE_PITCH][nnu_pkg::PITCH_W-1:0];
		shadow_cfg.dest_base    = cfg_words[nnu_pkg::REG_DEST_BASE];
		shadow_cfg.dst_width    = cfg_words[nnu_pkg::REG_DEST_WIDTH][nnu_pkg::DIM_W-1:0];
		shadow_cfg.dst_height   = cfg_words[nnu_pkg::REG_DEST_HEIGHT][nnu_pkg::DIM_W-1:0];
		shadow_cfg.dest_pitch   = cfg_words[nnu_pkg::REG_DEST_PITCH][nnu_pkg::PITCH_W-1:0];
	endtask

	// mostly sound settings with random content, about a quarter broken on purpose
	task automatic draw_config();
		int unsigned sw, sh, sp, dw, dh, dp;
		logic [31:0] sb, db;
		if ($urandom_range(0, 7) == 0) begin
			sw = $urandom_range(1, MAX_DIM);
			sh = $urandom_range(1, MAX_DIM);
			dw = $urandom_range(sw, MAX_DIM);
			dh = $urandom_range(sh, MAX_DIM);
			sp = $urandom_range(sw, MAX_PITCH);
			dp = $urandom_range(dw, MAX_PITCH);
		end else begin
			sw = $urandom_range(1, 12);
			sh = $urandom_range(1, 12);
			dw = sw * $urandom_range(1, 4) + $urandom_range(0, 3);
			dh = sh * $urandom_range(1, 4) + $urandom_range(0, 3);
			sp = sw + $urandom_range(0, 6);
			dp = dw + $urandom_range(0, 6);
		end
		sb = $urandom;
		db = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			sb = 32'hFFFF_FFFF;
			db = 32'hFFFF_FFFF;
		end
		if (sb == 0)
			sb = 32'h1;
		if (db == 0)
			db = 32'h1;
		case ($urandom_range(0, 55))
			0:  sb = 32'h0;
			1:  db = 32'h0;
			2:  sw = 0;
			3:  sh = 0;
			4:  dw = 0;
			5:  dh = 0;
			6:  sp = sw - 1;
			7:  dp = dw - 1;
			8:  dw = sw - 1;
			9:  dh = sh - 1;
			10: sw = $urandom_range(MAX_DIM + 1, 8191);
			11: dh = $urandom_range(MAX_DIM + 1, 8191);
			12: sp = $urandom_range(MAX_PITCH + 1, 16383);
			13: dp = $urandom_range(MAX_PITCH + 1, 16383);
			default: ;
		endcase
		cfg_words[nnu_pkg::REG_SOURCE_BASE]   = sb;
		cfg_words[nnu_pkg::REG_SOURCE_WIDTH]  = pad_word(sw, nnu_pkg::DIM_W);
		cfg_words[nnu_pkg::REG_SOURCE_HEIGHT] = pad_word(sh, nnu_pkg::DIM_W);
		cfg_words[nnu_pkg::REG_SOURCE_PITCH]  = pad_word(sp, nnu_pkg::PITCH_W);
		cfg_words[nnu_pkg::REG_DEST_BASE]     = db;
		cfg_words[nnu_pkg::REG_DEST_WIDTH]    = pad_word(dw, nnu_pkg::DIM_W);
		cfg_words[nnu_pkg::REG_DEST_HEIGHT]   = pad_word(dh, nnu_pkg::DIM_W);
		cfg_words[nnu_pkg::REG_DEST_PITCH]    = pad_word(dp, nnu_pkg::PITCH_W);
	endtask

	initial begin : stimulus
		logic [3:0]  cur_preset;
		int          sent;
		int unsigned n;
		cur_preset = P_RESET;
		sent = 0;
		for (int k = 0; k < NUM_CFG; k++)
			cfg_words[k] = PRESETS[P_RESET][k];
		shadow_cfg = '{source_base: 32'h0, src_width: 13'd1, src_height: 13'd1,
			source_pitch: 14'd1, dest_base: 32'h0, dst_width: 13'd1,
			dst_height: 13'd1, dest_pitch: 14'd1};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			if (ROWS[i].preset != cur_preset) begin
				wait_idle();
				for (int k = 0; k < NUM_CFG; k++)
					cfg_words[k] = PRESETS[ROWS[i].preset][k];
				apply_config();
				cur_preset = ROWS[i].preset;
			end
			send_beat(ROWS[i].x, ROWS[i].y, ROWS[i].typed, ROWS[i].want);
		end

		while (sent < RANDOM_BEATS) begin
			wait_idle();
			draw_config();
			apply_config();
			req_quiet = ($urandom_range(0, 3) == 0);
			rsp_quiet = ($urandom_range(0, 3) == 0);
			n = $urandom_range(40, 140);
			repeat (n)
				send_beat(pick_coord(shadow_cfg.dst_width),
					pick_coord(shadow_cfg.dst_height), 1'b0, REFUSED);
			sent += n;
		end

		wait_idle();
		repeat (LATENCY + 8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
